// ===== src/trle_pkg.sv =====
// Shared types and constants for the transparent run-length encoder.
// Used by the packer, datapath, controller and top level; no dependencies.
`default_nettype none

package trle_pkg;

  // Field and storage widths fixed by the interface
  localparam int CfgW     = 11;
  localparam int PixW     = 8;
  localparam int LenW     = 22;
  localparam int Lanes    = 8;
  localparam int LitDepth = 127;
  localparam int LitIdxW  = 7;
  localparam int CntW     = 4;

  // Code bytes
  localparam logic [7:0] CODE_EOL       = 8'h80;
  localparam logic [7:0] CODE_SKIP_BASE = 8'h80;
  localparam logic [7:0] CODE_SKIP_FULL = 8'hFF;
  localparam logic [7:0] CODE_TERM      = 8'hEE;
  localparam logic [6:0] CHUNK          = 7'h7F;

  // Configuration register indexes
  localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

  // Byte source select for the packer
  localparam logic [2:0] SRC_SKIP      = 3'd0;
  localparam logic [2:0] SRC_LIT_COUNT = 3'd1;
  localparam logic [2:0] SRC_LIT_DATA  = 3'd2;
  localparam logic [2:0] SRC_EOL       = 3'd3;
  localparam logic [2:0] SRC_TERM      = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic       load_px;
    logic       zr_inc;
    logic       zr_sub;
    logic       zr_clear;
    logic       lit_write;
    logic       lit_adv;
    logic       lit_done;
    logic       col_inc;
    logic       col_clear;
    logic       row_inc;
    logic       row_clear;
    logic       frame_clear;
    logic       push;
    logic [2:0] src;
    logic       term_last;
    logic       close;
  } trle_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic px_zero;
    logic lit_zero;
    logic lit_full_next;
    logic lit_full;
    logic lit_last;
    logic zr_zero;
    logic zr_ge_chunk;
    logic row_end;
    logic frame_end;
    logic push_ready;
  } trle_status_t;

endpackage

`default_nettype wire

// ===== src/trle_pack.sv =====
// Byte packer: gathers code bytes into 64-bit words and holds the output register.
// Depends on trle_pkg.
`default_nettype none

module trle_pack (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  input  wire logic [7:0]                   push_byte,
  input  wire logic                         push_done,
  input  wire logic [trle_pkg::LenW-1:0]    length,
  input  wire logic                         close,
  output logic                              push_ready,
  output logic                              code_valid,
  input  wire logic                         code_stall,
  output logic [8*trle_pkg::Lanes-1:0]      code_bytes,
  output logic [trle_pkg::CntW-1:0]         byte_count,
  output logic                              frame_done,
  output logic [trle_pkg::LenW-1:0]         frame_length
);
  import trle_pkg::*;

  logic [8*Lanes-1:0] acc_data, acc_data_next, base_data;
  logic [CntW-1:0]    acc_cnt, acc_cnt_next, base_cnt;
  logic               acc_closed, acc_closed_next;
  logic               acc_done, acc_done_next;
  logic [LenW-1:0]    acc_len, acc_len_next;
  logic               xfer;

  // Move a closed word into the output register when it is free
  assign xfer       = acc_closed && (!code_valid || !code_stall);
  assign push_ready = !acc_closed || xfer;

  // Accumulator next value
  always_comb begin
    base_data       = xfer ? '0 : acc_data;
    base_cnt        = xfer ? '0 : acc_cnt;
    acc_data_next   = base_data;
    acc_cnt_next    = base_cnt;
    acc_closed_next = xfer ? 1'b0 : acc_closed;
    acc_done_next   = xfer ? 1'b0 : acc_done;
    acc_len_next    = xfer ? '0 : acc_len;
    if (push) begin
      for (int i = 0; i < Lanes; i++) begin
        if (base_cnt == CntW'(i)) begin
          acc_data_next[8*i +: 8] = push_byte;
        end
      end
      acc_cnt_next    = base_cnt + CntW'(1);
      acc_closed_next = (base_cnt == CntW'(Lanes - 1)) || push_done;
      acc_done_next   = push_done;
      acc_len_next    = push_done ? length : '0;
    end else if (close && !acc_closed && (acc_cnt != '0)) begin
      acc_closed_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_data   <= '0;
      acc_cnt    <= '0;
      acc_closed <= 1'b0;
      acc_done   <= 1'b0;
      acc_len    <= '0;
    end else begin
      acc_data   <= acc_data_next;
      acc_cnt    <= acc_cnt_next;
      acc_closed <= acc_closed_next;
      acc_done   <= acc_done_next;
      acc_len    <= acc_len_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      code_valid <= 1'b0;
    end else if (xfer) begin
      code_valid <= 1'b1;
    end else if (!code_stall) begin
      code_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      code_bytes   <= acc_data;
      byte_count   <= acc_cnt;
      frame_done   <= acc_done;
      frame_length <= acc_len;
    end
  end

endmodule

`default_nettype wire

// ===== src/trle_dp.sv =====
// Encoder datapath: config registers, position and run counters, literal memory.
// Depends on trle_pkg and trle_pack.
`default_nettype none

module trle_dp #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [trle_pkg::PixW-1:0]    pixel,
  input  wire logic                         cfg_write,
  input  wire logic [0:0]                   cfg_index,
  input  wire logic [trle_pkg::CfgW-1:0]    cfg_data,
  input  wire trle_pkg::trle_cmd_t          cmd,
  output trle_pkg::trle_status_t            status,
  output logic                              code_valid,
  input  wire logic                         code_stall,
  output logic [8*trle_pkg::Lanes-1:0]      code_bytes,
  output logic [trle_pkg::CntW-1:0]         byte_count,
  output logic                              frame_done,
  output logic [trle_pkg::LenW-1:0]         frame_length
);
  import trle_pkg::*;

  localparam int ColW   = $clog2(MAX_WIDTH + 1);
  localparam int RowW   = $clog2(MAX_HEIGHT + 1);
  localparam int WCmpW  = (ColW > CfgW) ? ColW : CfgW;
  localparam int HCmpW  = (RowW > CfgW) ? RowW : CfgW;
  localparam int ZcW    = (ColW > LitIdxW) ? ColW : LitIdxW;
  localparam logic [WCmpW-1:0] WidthMax  = WCmpW'(MAX_WIDTH);
  localparam logic [HCmpW-1:0] HeightMax = HCmpW'(MAX_HEIGHT);

  logic [CfgW-1:0]    frame_width, frame_height;
  logic [PixW-1:0]    px;
  logic [ColW-1:0]    column;
  logic [RowW-1:0]    row_count;
  logic [ColW-1:0]    zero_run;
  logic [LitIdxW-1:0] lit_count, lit_idx, rd_addr;
  logic [LenW-1:0]    bytes_emitted;
  logic [PixW-1:0]    lit_mem [LitDepth];
  logic [PixW-1:0]    lit_rd;

  logic [WCmpW-1:0]   width_eff, width_ext;
  logic [HCmpW-1:0]   height_eff, height_ext;
  logic [ZcW-1:0]     zr_ext;
  logic [7:0]         push_byte;
  logic               push_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= CfgW'(8);
      frame_height <= CfgW'(8);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the dimensions to 1..max
  always_comb begin
    width_ext  = WCmpW'(frame_width);
    height_ext = HCmpW'(frame_height);
    if (frame_width == '0) begin
      width_eff = WCmpW'(1);
    end else if (width_ext > WidthMax) begin
      width_eff = WidthMax;
    end else begin
      width_eff = width_ext;
    end
    if (frame_height == '0) begin
      height_eff = HCmpW'(1);
    end else if (height_ext > HeightMax) begin
      height_eff = HeightMax;
    end else begin
      height_eff = height_ext;
    end
  end

  assign zr_ext = ZcW'(zero_run);

  // Status toward the controller
  always_comb begin
    status.px_zero       = (px == '0);
    status.lit_zero      = (lit_count == '0);
    status.lit_full_next = (lit_count == LitIdxW'(LitDepth - 1));
    status.lit_full      = (lit_count == CHUNK);
    status.lit_last      = ((lit_idx + LitIdxW'(1)) == lit_count);
    status.zr_zero       = (zero_run == '0);
    status.zr_ge_chunk   = (zr_ext >= ZcW'(CHUNK));
    status.row_end       = ((WCmpW'(column) + WCmpW'(1)) >= width_eff);
    status.frame_end     = ((HCmpW'(row_count) + HCmpW'(1)) >= height_eff);
    status.push_ready    = push_ready;
  end

  // Pixel register
  always_ff @(posedge clk) begin
    if (cmd.load_px) begin
      px <= pixel;
    end
  end

  // Position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      column    <= '0;
      row_count <= '0;
    end else begin
      if (cmd.col_clear) begin
        column <= '0;
      end else if (cmd.col_inc) begin
        column <= column + ColW'(1);
      end
      if (cmd.row_clear) begin
        row_count <= '0;
      end else if (cmd.row_inc) begin
        row_count <= row_count + RowW'(1);
      end
    end
  end

  // Transparent run counter
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_run <= '0;
    end else if (cmd.frame_clear || cmd.zr_clear) begin
      zero_run <= '0;
    end else if (cmd.zr_sub) begin
      zero_run <= ColW'(zr_ext - ZcW'(CHUNK));
    end else if (cmd.zr_inc) begin
      zero_run <= zero_run + ColW'(1);
    end
  end

  // Literal count and read index
  always_ff @(posedge clk) begin
    if (rst) begin
      lit_count <= '0;
      lit_idx   <= '0;
    end else begin
      if (cmd.lit_done || cmd.frame_clear) begin
        lit_count <= '0;
      end else if (cmd.lit_write) begin
        lit_count <= lit_count + LitIdxW'(1);
      end
      if (cmd.lit_done) begin
        lit_idx <= '0;
      end else if (cmd.lit_adv) begin
        lit_idx <= lit_idx + LitIdxW'(1);
      end
    end
  end

  // Literal memory: one write port, registered read that runs one entry ahead
  assign rd_addr = cmd.lit_adv ? (lit_idx + LitIdxW'(1)) : lit_idx;

  always_ff @(posedge clk) begin
    if (cmd.lit_write) begin
      lit_mem[lit_count] <= px;
    end
  end

  always_ff @(posedge clk) begin
    lit_rd <= lit_mem[rd_addr];
  end

  // Frame byte count; terminator bytes are not counted
  always_ff @(posedge clk) begin
    if (rst || cmd.frame_clear) begin
      bytes_emitted <= '0;
    end else if (cmd.push && (cmd.src != SRC_TERM)) begin
      bytes_emitted <= bytes_emitted + LenW'(1);
    end
  end

  // Select the code byte to push
  always_comb begin
    case (cmd.src)
      SRC_SKIP: begin
        if (status.zr_ge_chunk) begin
          push_byte = CODE_SKIP_FULL;
        end else begin
          push_byte = CODE_SKIP_BASE | {1'b0, LitIdxW'(zr_ext)};
        end
      end
      SRC_LIT_COUNT: push_byte = {1'b0, lit_count};
      SRC_LIT_DATA:  push_byte = lit_rd;
      SRC_EOL:       push_byte = CODE_EOL;
      SRC_TERM:      push_byte = CODE_TERM;
      default:       push_byte = '0;
    endcase
  end

  trle_pack u_pack (
    .clk          (clk),
    .rst          (rst),
    .push         (cmd.push),
    .push_byte    (push_byte),
    .push_done    (cmd.term_last),
    .length       (bytes_emitted),
    .close        (cmd.close),
    .push_ready   (push_ready),
    .code_valid   (code_valid),
    .code_stall   (code_stall),
    .code_bytes   (code_bytes),
    .byte_count   (byte_count),
    .frame_done   (frame_done),
    .frame_length (frame_length)
  );

endmodule

`default_nettype wire

// ===== src/trle_ctrl.sv =====
// Encoder controller: sequences skip, literal, end-of-line and terminator codes.
// Depends on trle_pkg.
`default_nettype none

module trle_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   pixel_valid,
  output logic                        pixel_stall,
  input  wire trle_pkg::trle_status_t status,
  output trle_pkg::trle_cmd_t         cmd
);
  import trle_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECIDE   = 3'd1;
  localparam logic [2:0] S_SKIP     = 3'd2;
  localparam logic [2:0] S_LIT_CNT  = 3'd3;
  localparam logic [2:0] S_LIT_DATA = 3'd4;
  localparam logic [2:0] S_ROWCHK   = 3'd5;
  localparam logic [2:0] S_EOL      = 3'd6;
  localparam logic [2:0] S_TERM     = 3'd7;

  logic [2:0] state, state_next;
  logic       row_phase, row_phase_next;
  logic [1:0] term_cnt, term_cnt_next;
  logic       closing, closing_next;

  // Take a pixel only when idle and no partial word still needs closing
  assign pixel_stall = rst || (state != S_IDLE) || closing;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    row_phase_next = row_phase;
    term_cnt_next  = term_cnt;
    closing_next   = 1'b0;
    case (state)
      S_IDLE: begin
        if (closing) begin
          cmd.close = 1'b1;
        end else if (pixel_valid) begin
          cmd.load_px = 1'b1;
          state_next  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (status.px_zero) begin
          cmd.zr_inc = 1'b1;
          if (!status.lit_zero) begin
            row_phase_next = 1'b0;
            state_next     = S_LIT_CNT;
          end else if (status.row_end) begin
            state_next = S_EOL;
          end else begin
            cmd.col_inc = 1'b1;
            state_next  = S_IDLE;
          end
        end else begin
          cmd.lit_write = 1'b1;
          if (!status.zr_zero) begin
            state_next = S_SKIP;
          end else if (status.lit_full_next) begin
            row_phase_next = 1'b0;
            state_next     = S_LIT_CNT;
          end else if (status.row_end) begin
            row_phase_next = 1'b1;
            state_next     = S_LIT_CNT;
          end else begin
            cmd.col_inc = 1'b1;
            state_next  = S_IDLE;
          end
        end
      end
      // Emit full skips, then the remainder
      S_SKIP: begin
        cmd.src = SRC_SKIP;
        if (status.zr_zero) begin
          if (status.lit_full) begin
            row_phase_next = 1'b0;
            state_next     = S_LIT_CNT;
          end else begin
            state_next = S_ROWCHK;
          end
        end else if (status.push_ready) begin
          cmd.push = 1'b1;
          if (status.zr_ge_chunk) begin
            cmd.zr_sub = 1'b1;
          end else begin
            cmd.zr_clear = 1'b1;
          end
        end
      end
      S_LIT_CNT: begin
        cmd.src = SRC_LIT_COUNT;
        if (status.push_ready) begin
          cmd.push   = 1'b1;
          state_next = S_LIT_DATA;
        end
      end
      S_LIT_DATA: begin
        cmd.src = SRC_LIT_DATA;
        if (status.push_ready) begin
          cmd.push = 1'b1;
          if (status.lit_last) begin
            cmd.lit_done = 1'b1;
            state_next   = row_phase ? S_EOL : S_ROWCHK;
          end else begin
            cmd.lit_adv = 1'b1;
          end
        end
      end
      S_ROWCHK: begin
        if (status.row_end) begin
          if (!status.lit_zero) begin
            row_phase_next = 1'b1;
            state_next     = S_LIT_CNT;
          end else begin
            state_next = S_EOL;
          end
        end else begin
          cmd.col_inc  = 1'b1;
          closing_next = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_EOL: begin
        cmd.src = SRC_EOL;
        if (status.push_ready) begin
          cmd.push      = 1'b1;
          cmd.zr_clear  = 1'b1;
          cmd.col_clear = 1'b1;
          if (status.frame_end) begin
            cmd.row_clear = 1'b1;
            term_cnt_next = '0;
            state_next    = S_TERM;
          end else begin
            cmd.row_inc  = 1'b1;
            closing_next = 1'b1;
            state_next   = S_IDLE;
          end
        end
      end
      // Three terminator bytes; the last one closes the frame's final word
      S_TERM: begin
        cmd.src       = SRC_TERM;
        cmd.term_last = (term_cnt == 2'd2);
        if (status.push_ready) begin
          cmd.push = 1'b1;
          if (term_cnt == 2'd2) begin
            cmd.frame_clear = 1'b1;
            state_next      = S_IDLE;
          end else begin
            term_cnt_next = term_cnt + 2'd1;
          end
        end else begin
          cmd.term_last = 1'b0;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row_phase <= 1'b0;
      term_cnt  <= '0;
      closing   <= 1'b0;
    end else begin
      state     <= state_next;
      row_phase <= row_phase_next;
      term_cnt  <= term_cnt_next;
      closing   <= closing_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/transparent_run_length_encoder_unit.sv =====
// Transparent run-length encoder for one 8-bit sprite frame, pixels arriving bottom
// row first. A pixel that causes no code bytes is accepted, then decided in the
// controller. A pixel that causes code bytes is accepted and decided, pushes its
// bytes, then finishes a skip run if it had one, runs the row check after a skip or
// a literal flush that does not end the row, and closes a trailing partial word
// unless the frame ends. A full 8-byte word moves on with no bubble while the output
// is free. The literal memory is read one byte per cycle while the packer can take
// bytes; a literal chunk holds up to 127 pixels. Output stalls hold the byte
// sequencer. Configuration writes are taken in any cycle outside reset and should
// only be issued while the encoder is idle.
// Depends on trle_pkg, trle_ctrl and trle_dp.
`default_nettype none

module transparent_run_length_encoder_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         pixel_valid,
  output logic                              pixel_stall,
  input  wire logic [trle_pkg::PixW-1:0]    pixel,
  output logic                              code_valid,
  input  wire logic                         code_stall,
  output logic [8*trle_pkg::Lanes-1:0]      code_bytes,
  output logic [trle_pkg::CntW-1:0]         byte_count,
  output logic                              frame_done,
  output logic [trle_pkg::LenW-1:0]         frame_length,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [0:0]                   cfg_index,
  input  wire logic [trle_pkg::CfgW-1:0]    cfg_data
);
  import trle_pkg::*;

  trle_cmd_t    cmd;
  trle_status_t status;

  // Register writes are always accepted outside reset
  assign cfg_ready = !rst;

  trle_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .status      (status),
    .cmd         (cmd)
  );

  trle_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .pixel        (pixel),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status),
    .code_valid   (code_valid),
    .code_stall   (code_stall),
    .code_bytes   (code_bytes),
    .byte_count   (byte_count),
    .frame_done   (frame_done),
    .frame_length (frame_length)
  );

endmodule

`default_nettype wire
